[hdl/length_prefixed_frame_checker_defines.svh]
// Assertion macros for the checker file of this block.
`ifndef LENGTH_PREFIXED_FRAME_CHECKER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_CHECKER_DEFINES_SVH

// Condition in this cycle implies a consequence in the same cycle.
`define LPFC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpfc assertion failed");

// Condition in this cycle implies a consequence in the next cycle.
`define LPFC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpfc assertion failed");

`endif

[hdl/lpfc_pkg.sv]
package lpfc_pkg;

	localparam logic [31:0] CRC_POLY        = 32'h82F6_3B78;
	localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
	localparam logic [32:0] POS_MAX         = 33'h1_FFFF_FFFF;
	localparam logic [32:0] PREFIX_BYTES    = 33'd4;
	localparam logic [32:0] HEADER_END      = 33'd20;
	localparam logic [31:0] HEADER_BYTES    = 32'd16;
	localparam logic [31:0] MAX_FRAME_RESET = 32'd16777216;
	localparam logic [7:0]  SCHEMA_RESET    = 8'd1;
	localparam int          CFG_INDEX_W     = 2;
	localparam int          VIOL_W          = 14;

	// Violation bit positions.
	localparam int VIO_PREFIX_SHORT = 0;
	localparam int VIO_LEN_ZERO     = 1;
	localparam int VIO_UNDER_HEADER = 2;
	localparam int VIO_OVER_LIMIT   = 3;
	localparam int VIO_FRAME_SHORT  = 4;
	localparam int VIO_OVERLONG     = 5;
	localparam int VIO_UNDERLONG    = 6;
	localparam int VIO_JSON_CRC     = 7;
	localparam int VIO_CRC_WRONG    = 8;
	localparam int VIO_ENC_MISMATCH = 9;
	localparam int VIO_ENC_UNKNOWN  = 10;
	localparam int VIO_FLAGS        = 11;
	localparam int VIO_FAM_UNKNOWN  = 12;
	localparam int VIO_SCHEMA_MAJOR = 13;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_MAX_FRAME    = 2'd0,
		CFG_SCHEMA_MAJOR = 2'd1,
		CFG_JSON_CODE    = 2'd2,
		CFG_FAMILY_MAP   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last;
	} in_beat_t;

	typedef struct packed {
		logic              frame_valid;
		logic [VIOL_W-1:0] violations;
		logic              encoding;
		logic [1:0]        family;
		logic [7:0]        schema_minor;
		logic [31:0]       payload_length;
		logic [31:0]       stored_checksum;
		logic [32:0]       wire_length;
	} verdict_t;

	// One byte of reflected CRC-32C, bit by bit, LSB first.
	function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

[hdl/length_prefixed_frame_checker.sv]
// Length-prefixed frame checker.
// Bytes of one buffer enter on the byte channel (byte_valid, byte_ready, byte_beat),
// one beat per byte, and the final byte of the buffer carries last = 1. The buffer is a
// 4-byte little-endian frame length, a 16-byte header and the payload; a CRC-32C is run
// over the payload bytes. For every beat with last set, one verdict beat leaves on the
// verdict channel (verdict_valid, verdict_ready, verdict); other beats give no output.
// Configuration registers are written through cfg_valid/cfg_index/cfg_data, which is
// always ready, and should only be written while no buffer is in flight.
// An accepted byte sits in the input register; from there it updates the frame state
// and, if last, the verdict register, which shows the verdict. Throughput is one byte
// per cycle while no last byte waits on a stalled verdict: the whole per-byte work,
// including the unrolled eight-step CRC update and the verdict compares, fits between
// the input register and the verdict register.
// When the receiver stalls, the verdict holds in its register while non-last bytes keep
// flowing; a last byte waits in the input register until the verdict register is free,
// and byte_ready stays low while it waits.
// Reset clears the frame state, both pipeline registers and loads the configuration
// registers with their defaults (limit 16 MiB, schema major 1, json code 0, map 0).
module length_prefixed_frame_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_valid,
	output logic                          byte_ready,
	input  lpfc_pkg::in_beat_t            byte_beat,
	output logic                          verdict_valid,
	input  logic                          verdict_ready,
	output lpfc_pkg::verdict_t            verdict,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lpfc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [31:0]                   cfg_data
);
	import lpfc_pkg::*;

	// Configuration registers.
	logic [31:0] max_frame_q;
	logic [7:0]  schema_major_cfg_q;
	logic        json_code_q;
	logic [2:0]  family_map_q;

	// Input register.
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;

	// Frame state.
	logic [32:0] pos_q;
	logic [31:0] frame_len_q;
	logic [7:0]  enc_q;
	logic [7:0]  fam_q;
	logic [7:0]  major_q;
	logic [7:0]  minor_q;
	logic        flags_nz_q;
	logic [31:0] pay_len_q;
	logic [31:0] chk_q;
	logic [31:0] crc_q;

	// Next-state values after taking byte_s1.
	logic [32:0] pos_n;
	logic [31:0] frame_len_n;
	logic [7:0]  enc_n;
	logic [7:0]  fam_n;
	logic [7:0]  major_n;
	logic [7:0]  minor_n;
	logic        flags_nz_n;
	logic [31:0] pay_len_n;
	logic [31:0] chk_n;
	logic [31:0] crc_n;

	logic [3:0]  hdr_idx;
	logic        in_prefix;
	logic        in_header;
	logic        in_payload;

	logic [32:0]       wire_len;
	logic [32:0]       expect_len;
	logic [VIOL_W-1:0] viol;
	logic              enc_known;
	logic              fam_known;
	logic [3:0]        map_ext;
	verdict_t          verdict_d;

	logic        advance;
	verdict_t    verdict_q;
	logic        verdict_valid_q;

	assign cfg_ready = 1'b1;

	// A non-last byte never needs the verdict register, so it moves on at once.
	assign advance    = valid_s1 && (!last_s1 || !verdict_valid_q || verdict_ready);
	assign byte_ready = !valid_s1 || advance;

	assign verdict_valid = verdict_valid_q;
	assign verdict       = verdict_q;

	// Byte placement: prefix, header lanes, or payload covered by the frame length.
	assign hdr_idx    = pos_q[3:0] - 4'd4;
	assign in_prefix  = pos_q < PREFIX_BYTES;
	assign in_header  = !in_prefix && (pos_q < HEADER_END);
	assign in_payload = !in_prefix && !in_header && (pos_q < ({1'b0, frame_len_q} + PREFIX_BYTES));

	always_comb begin
		pos_n       = (pos_q == POS_MAX) ? pos_q : pos_q + 33'd1;
		frame_len_n = frame_len_q;
		enc_n       = enc_q;
		fam_n       = fam_q;
		major_n     = major_q;
		minor_n     = minor_q;
		flags_nz_n  = flags_nz_q;
		pay_len_n   = pay_len_q;
		chk_n       = chk_q;
		crc_n       = crc_q;
		if (in_prefix) begin
			frame_len_n[8*pos_q[1:0] +: 8] = byte_s1;
		end else if (in_header) begin
			unique case (hdr_idx[3:2])
				2'd0: begin
					unique case (hdr_idx[1:0])
						2'd0: enc_n   = byte_s1;
						2'd1: fam_n   = byte_s1;
						2'd2: major_n = byte_s1;
						2'd3: minor_n = byte_s1;
						default: enc_n = enc_q;
					endcase
				end
				2'd1: flags_nz_n = flags_nz_q || (byte_s1 != 8'd0);
				2'd2: pay_len_n[8*hdr_idx[1:0] +: 8] = byte_s1;
				2'd3: chk_n[8*hdr_idx[1:0] +: 8] = byte_s1;
				default: flags_nz_n = flags_nz_q;
			endcase
		end else if (in_payload) begin
			crc_n = crc32c_byte(crc_q, byte_s1);
		end
	end

	// Verdict from the state as it stands after the last byte.
	assign wire_len   = {1'b0, frame_len_n} + PREFIX_BYTES;
	assign expect_len = {1'b0, pay_len_n} + {1'b0, HEADER_BYTES};
	assign enc_known  = enc_n <= 8'd1;
	assign fam_known  = fam_n <= 8'd2;
	assign map_ext    = {1'b0, family_map_q};

	always_comb begin
		viol = '0;
		// Framing checks: only the first failing one is reported.
		priority if (pos_n < PREFIX_BYTES) begin
			viol[VIO_PREFIX_SHORT] = 1'b1;
		end else if (frame_len_n == 32'd0) begin
			viol[VIO_LEN_ZERO] = 1'b1;
		end else if (frame_len_n > max_frame_q) begin
			viol[VIO_OVER_LIMIT] = 1'b1;
		end else if (frame_len_n < HEADER_BYTES) begin
			viol[VIO_UNDER_HEADER] = 1'b1;
		end else if (pos_n < wire_len) begin
			viol[VIO_FRAME_SHORT] = 1'b1;
		end else if ({1'b0, frame_len_n} > expect_len) begin
			viol[VIO_OVERLONG] = 1'b1;
		end else if ({1'b0, frame_len_n} < expect_len) begin
			viol[VIO_UNDERLONG] = 1'b1;
		end else begin
			// Field checks gather every failing bit.
			viol[VIO_ENC_UNKNOWN]  = !enc_known;
			viol[VIO_FAM_UNKNOWN]  = !fam_known;
			viol[VIO_SCHEMA_MAJOR] = major_n != schema_major_cfg_q;
			viol[VIO_FLAGS]        = flags_nz_n;
			viol[VIO_ENC_MISMATCH] = enc_known && fam_known && (enc_n[0] != map_ext[fam_n[1:0]]);
			if (enc_known) begin
				if (enc_n[0] == json_code_q) begin
					viol[VIO_JSON_CRC] = chk_n != 32'd0;
				end else begin
					viol[VIO_CRC_WRONG] = chk_n != ~crc_n;
				end
			end
		end
	end

	always_comb begin
		verdict_d             = '0;
		verdict_d.frame_valid = viol == '0;
		verdict_d.violations  = viol;
		if (viol == '0) begin
			verdict_d.encoding        = enc_n[0];
			verdict_d.family          = fam_n[1:0];
			verdict_d.schema_minor    = minor_n;
			verdict_d.payload_length  = pay_len_n;
			verdict_d.stored_checksum = chk_n;
			verdict_d.wire_length     = wire_len;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q        <= MAX_FRAME_RESET;
			schema_major_cfg_q <= SCHEMA_RESET;
			json_code_q        <= 1'b0;
			family_map_q       <= 3'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_MAX_FRAME:    max_frame_q        <= cfg_data;
				CFG_SCHEMA_MAJOR: schema_major_cfg_q <= cfg_data[7:0];
				CFG_JSON_CODE:    json_code_q        <= cfg_data[0];
				CFG_FAMILY_MAP:   family_map_q       <= cfg_data[2:0];
				default:          json_code_q        <= json_code_q;
			endcase
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= byte_beat.data_byte;
			last_s1 <= byte_beat.last;
		end
	end

	// Frame state: updated per byte, cleared when a last byte moves into the verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			frame_len_q <= '0;
			enc_q       <= '0;
			fam_q       <= '0;
			major_q     <= '0;
			minor_q     <= '0;
			flags_nz_q  <= 1'b0;
			pay_len_q   <= '0;
			chk_q       <= '0;
			crc_q       <= CRC_INIT;
		end else if (advance) begin
			if (last_s1) begin
				pos_q       <= '0;
				frame_len_q <= '0;
				enc_q       <= '0;
				fam_q       <= '0;
				major_q     <= '0;
				minor_q     <= '0;
				flags_nz_q  <= 1'b0;
				pay_len_q   <= '0;
				chk_q       <= '0;
				crc_q       <= CRC_INIT;
			end else begin
				pos_q       <= pos_n;
				frame_len_q <= frame_len_n;
				enc_q       <= enc_n;
				fam_q       <= fam_n;
				major_q     <= major_n;
				minor_q     <= minor_n;
				flags_nz_q  <= flags_nz_n;
				pay_len_q   <= pay_len_n;
				chk_q       <= chk_n;
				crc_q       <= crc_n;
			end
		end
	end

	// Verdict register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			verdict_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			verdict_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			verdict_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			verdict_q <= verdict_d;
		end
	end

endmodule

[hdl/lpfc_checker.sv]
`include "length_prefixed_frame_checker_defines.svh"

module lpfc_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  verdict_valid,
	input logic                  verdict_ready,
	input lpfc_pkg::verdict_t    verdict
);
	import lpfc_pkg::*;

	// A stalled verdict stays offered and unchanged.
	`LPFC_ASSERT_NXT(a_verdict_hold, clk, arst_n, verdict_valid && !verdict_ready, verdict_valid && $stable(verdict))

	// The valid flag agrees with the violation set.
	`LPFC_ASSERT_IMP(a_valid_flag, clk, arst_n, verdict_valid, verdict.frame_valid == (verdict.violations == '0))

	// A failed frame shows no header fields.
	`LPFC_ASSERT_IMP(a_zero_fields, clk, arst_n, verdict_valid && !verdict.frame_valid, verdict.encoding == 1'b0 && verdict.family == 2'd0 && verdict.schema_minor == 8'd0 && verdict.payload_length == 32'd0 && verdict.stored_checksum == 32'd0 && verdict.wire_length == 33'd0)

	// At most one framing violation, and none of the field checks beside it.
	`LPFC_ASSERT_IMP(a_framing_first, clk, arst_n, verdict_valid && verdict.violations[6:0] != 7'd0, $onehot(verdict.violations[6:0]) && verdict.violations[13:7] == 7'd0)

endmodule

bind length_prefixed_frame_checker lpfc_checker u_lpfc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.verdict_valid (verdict_valid),
	.verdict_ready (verdict_ready),
	.verdict       (verdict)
);
